FILE: src/grom_pkg.sv
// Shared types, widths and codes of the greedy rectangle overlap matcher.
// Used by every module of the block; depends on nothing.
package grom_pkg;

   // Table and coordinate sizes.
   localparam int TABLE_DEPTH = 64;
   localparam int COORD_BITS  = 12;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int TAG_BITS    = 8;
   localparam int OP_BITS     = 2;
   localparam int SLOT_BITS   = 6;
   localparam int SCORE_BITS  = 32;

   // Score datapath widths.
   localparam int EXT_BITS   = COORD_BITS + 1;
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int UNION_BITS = AREA_BITS + 1;
   localparam int SQ_BITS    = 2 * EXT_BITS;
   localparam int DSQ_BITS   = SQ_BITS + 1;
   localparam int LSQ_BITS   = AREA_BITS + 1;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_BITS   = LSQ_BITS + 2 * FRAC_BITS;
   localparam int DEN_BITS   = DSQ_BITS;
   localparam int ROOT_BITS  = (NUM_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int OV_BITS    = FRAC_BITS + 1;
   localparam int PROD_BITS  = OV_BITS + ROOT_BITS;
   localparam int DCNT_BITS  = $clog2(NUM_BITS + 1);
   localparam int SCNT_BITS  = $clog2(ROOT_BITS + 1);
   localparam int RECT_BITS  = 4 * COORD_BITS;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = 1;
   localparam int QFILL_BITS  = 2;

   // Operation codes of the request field.
   localparam logic [OP_BITS-1:0] REQ_OP_CLEAR  = 2'd0;
   localparam logic [OP_BITS-1:0] REQ_OP_APPEND = 2'd1;
   localparam logic [OP_BITS-1:0] REQ_OP_MATCH  = 2'd2;

   localparam logic [SCORE_BITS-1:0] SCORE_SAT = '1;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_APPEND,
      CMD_MATCH
   } cmd_op_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } rect_type;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [COORD_BITS-1:0] rect_w;
      logic [COORD_BITS-1:0] rect_h;
      logic [TAG_BITS-1:0]   detection_tag;
   } req_payload_type;

   typedef struct packed {
      logic                  matched;
      logic [SLOT_BITS-1:0]  match_slot;
      logic [SCORE_BITS-1:0] match_score;
      logic [TAG_BITS-1:0]   echo_tag;
   } rsp_payload_type;

   typedef struct packed {
      cmd_op_type          op;
      rect_type            rect;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_READ,
      B_SPAN,
      B_PROD,
      B_SUMS,
      B_CHECK,
      B_DIV,
      B_SQRT,
      B_MUL,
      B_SCORE,
      B_CMP,
      B_DONE
   } back_state_type;

endpackage

FILE: src/grom_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on grom_pkg for its widths.
module grom_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [grom_pkg::NUM_BITS-1:0] num,
   input  logic [grom_pkg::DEN_BITS-1:0] den,
   output logic                          done,
   output logic [grom_pkg::NUM_BITS-1:0] quo
);

   logic [grom_pkg::NUM_BITS-1:0]  q_ff, q_in;
   logic [grom_pkg::DEN_BITS-1:0]  rem_ff, rem_in;
   logic [grom_pkg::DEN_BITS-1:0]  den_ff, den_in;
   logic [grom_pkg::DCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [grom_pkg::DEN_BITS:0]    shifted;
   logic [grom_pkg::DEN_BITS:0]    diff;
   logic                           fits;

   // One trial subtraction of the shifted remainder.
   always_comb begin
      shifted = {rem_ff, q_ff[grom_pkg::NUM_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
   end

   // Next values of the iteration registers.
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = num;
         rem_in = '0;
         den_in = den;
         cnt_in = grom_pkg::DCNT_BITS'(grom_pkg::NUM_BITS);
      end else if (cnt_ff != '0) begin
         q_in    = {q_ff[grom_pkg::NUM_BITS-2:0], fits};
         rem_in  = fits ? diff[grom_pkg::DEN_BITS-1:0] : shifted[grom_pkg::DEN_BITS-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == grom_pkg::DCNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

FILE: src/grom_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on grom_pkg for its widths.
module grom_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [grom_pkg::RAD_BITS-1:0]  radicand,
   output logic                           done,
   output logic [grom_pkg::ROOT_BITS-1:0] root
);

   localparam int REM_BITS = grom_pkg::ROOT_BITS + 2;

   logic [grom_pkg::RAD_BITS-1:0]  val_ff, val_in;
   logic [grom_pkg::ROOT_BITS-1:0] root_ff, root_in;
   logic [REM_BITS-1:0]            rem_ff, rem_in;
   logic [grom_pkg::SCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [REM_BITS+1:0]            shifted;
   logic [REM_BITS+1:0]            trial;
   logic                           fits;

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      shifted = {rem_ff, val_ff[grom_pkg::RAD_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      fits    = (shifted >= trial);
   end

   always_comb begin
      val_in  = val_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = grom_pkg::SCNT_BITS'(grom_pkg::ROOT_BITS);
      end else if (cnt_ff != '0) begin
         val_in  = {val_ff[grom_pkg::RAD_BITS-3:0], 2'b00};
         root_in = {root_ff[grom_pkg::ROOT_BITS-2:0], fits};
         rem_in  = fits ? REM_BITS'(shifted - trial) : REM_BITS'(shifted);
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == grom_pkg::SCNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: src/grom_front.sv
// Front end: accepts request beats, classifies the op and queues commands.
// Depends on grom_pkg for the payload and command types.
module grom_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  grom_pkg::req_payload_type req_item,
   output grom_pkg::cmd_chan_type    cmd_chan,
   input  logic                      cmd_pop
);

   grom_pkg::cmd_type               queue_ff [grom_pkg::QUEUE_DEPTH];
   logic [grom_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [grom_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [grom_pkg::QFILL_BITS-1:0] fill_ff, fill_in;
   grom_pkg::cmd_type               cmd_new;
   logic                            known_op;
   logic                            push;
   logic                            pop;

   // Classify the beat; an unknown op is taken and dropped.
   always_comb begin
      cmd_new.rect.x = req_item.rect_x;
      cmd_new.rect.y = req_item.rect_y;
      cmd_new.rect.w = req_item.rect_w;
      cmd_new.rect.h = req_item.rect_h;
      cmd_new.tag    = req_item.detection_tag;
      cmd_new.op     = grom_pkg::CMD_CLEAR;
      known_op       = 1'b1;
      case (req_item.op)
         grom_pkg::REQ_OP_CLEAR:  cmd_new.op = grom_pkg::CMD_CLEAR;
         grom_pkg::REQ_OP_APPEND: cmd_new.op = grom_pkg::CMD_APPEND;
         grom_pkg::REQ_OP_MATCH:  cmd_new.op = grom_pkg::CMD_MATCH;
         default:                 known_op   = 1'b0;
      endcase
   end

   assign busy = (fill_ff == grom_pkg::QFILL_BITS'(grom_pkg::QUEUE_DEPTH));
   assign push = start && !busy && known_op;
   assign pop  = cmd_pop && (fill_ff != '0);

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_chan.valid = (fill_ff != '0);
   assign cmd_chan.cmd   = queue_ff[rd_ptr_ff];

endmodule

FILE: src/grom_back.sv
// Back end: holds the candidate table and executes clear, append and match.
// Depends on grom_pkg, grom_div and grom_sqrt.
module grom_back (
   input  logic                      clock,
   input  logic                      reset,
   input  grom_pkg::cmd_chan_type    cmd_chan,
   output logic                      cmd_pop,
   output logic                      rsp_strobe,
   output grom_pkg::rsp_payload_type rsp_item
);

   localparam int EB = grom_pkg::EXT_BITS;
   localparam int CB = grom_pkg::COORD_BITS;

   grom_pkg::back_state_type        state_ff, state_in;
   grom_pkg::rect_type              rect_mem_ff [grom_pkg::TABLE_DEPTH];
   grom_pkg::rect_type              cand_ff;
   grom_pkg::rect_type              query_ff;
   logic [grom_pkg::TAG_BITS-1:0]   tag_ff;
   logic [grom_pkg::TABLE_DEPTH-1:0] in_use_ff;
   logic [grom_pkg::CNT_BITS-1:0]   count_ff;
   logic [grom_pkg::CNT_BITS-1:0]   slot_ff;
   logic [grom_pkg::IDX_BITS-1:0]   best_slot_ff;
   logic [grom_pkg::SCORE_BITS-1:0] best_ff;
   logic [grom_pkg::SCORE_BITS-1:0] score_ff;

   // Span and center registers.
   logic [EB-1:0] ow_ff, oh_ff, adx_ff, ady_ff;
   logic [CB-1:0] lw_ff, lh_ff;
   // Product and sum registers.
   logic [grom_pkg::AREA_BITS-1:0]  a1_ff, a2_ff;
   logic [grom_pkg::SQ_BITS-1:0]    a0_ff, dx2_ff, dy2_ff;
   logic [grom_pkg::AREA_BITS-1:0]  lw2_ff, lh2_ff;
   logic [grom_pkg::SQ_BITS-1:0]    a0s_ff;
   logic [grom_pkg::UNION_BITS-1:0] uni_ff;
   logic [grom_pkg::DSQ_BITS-1:0]   dsq_ff;
   logic [grom_pkg::LSQ_BITS-1:0]   lsq_ff;
   logic [grom_pkg::PROD_BITS-1:0]  prod_ff;

   logic                            cmd_take;
   logic                            div_start;
   logic                            sqrt_start;
   logic                            slot_used;
   logic                            scan_end;
   logic                            ov_done, x_done, root_done;
   logic [grom_pkg::NUM_BITS-1:0]   ov_quo, x_quo;
   logic [grom_pkg::ROOT_BITS-1:0]  root;
   logic [grom_pkg::IDX_BITS-1:0]   slot_idx;
   logic                            table_full;
   logic                            zero_case;
   logic                            coincident;

   // Span geometry between the query and the candidate.
   logic [EB-1:0] qe_x, qe_y, ce_x, ce_y, lo_x, lo_y, hi_x, hi_y;
   logic [EB-1:0] qc_x, qc_y, cc_x, cc_y;
   logic [EB:0]   lw_sum, lh_sum;

   always_comb begin
      qe_x   = {1'b0, query_ff.x} + {1'b0, query_ff.w};
      qe_y   = {1'b0, query_ff.y} + {1'b0, query_ff.h};
      ce_x   = {1'b0, cand_ff.x} + {1'b0, cand_ff.w};
      ce_y   = {1'b0, cand_ff.y} + {1'b0, cand_ff.h};
      lo_x   = (query_ff.x > cand_ff.x) ? {1'b0, query_ff.x} : {1'b0, cand_ff.x};
      lo_y   = (query_ff.y > cand_ff.y) ? {1'b0, query_ff.y} : {1'b0, cand_ff.y};
      hi_x   = (qe_x < ce_x) ? qe_x : ce_x;
      hi_y   = (qe_y < ce_y) ? qe_y : ce_y;
      qc_x   = {1'b0, query_ff.x} + {2'b0, query_ff.w[CB-1:1]};
      qc_y   = {1'b0, query_ff.y} + {2'b0, query_ff.h[CB-1:1]};
      cc_x   = {1'b0, cand_ff.x} + {2'b0, cand_ff.w[CB-1:1]};
      cc_y   = {1'b0, cand_ff.y} + {2'b0, cand_ff.h[CB-1:1]};
      lw_sum = {2'b0, query_ff.w} + {2'b0, cand_ff.w};
      lh_sum = {2'b0, query_ff.h} + {2'b0, cand_ff.h};
   end

   assign slot_idx   = slot_ff[grom_pkg::IDX_BITS-1:0];
   assign slot_used  = in_use_ff[slot_idx];
   assign scan_end   = (slot_ff >= count_ff);
   assign table_full = (count_ff == grom_pkg::CNT_BITS'(grom_pkg::TABLE_DEPTH));
   assign zero_case  = (uni_ff == '0) || (a0s_ff == '0);
   assign coincident = (dsq_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         grom_pkg::B_IDLE: begin
            if (cmd_chan.valid && cmd_chan.cmd.op == grom_pkg::CMD_MATCH) begin
               state_in = grom_pkg::B_READ;
            end
         end
         grom_pkg::B_READ: begin
            if (scan_end) begin
               state_in = grom_pkg::B_DONE;
            end else if (!slot_used) begin
               state_in = grom_pkg::B_SPAN;
            end
         end
         grom_pkg::B_SPAN:  state_in = grom_pkg::B_PROD;
         grom_pkg::B_PROD:  state_in = grom_pkg::B_SUMS;
         grom_pkg::B_SUMS:  state_in = grom_pkg::B_CHECK;
         grom_pkg::B_CHECK: begin
            state_in = (zero_case || coincident) ? grom_pkg::B_CMP : grom_pkg::B_DIV;
         end
         grom_pkg::B_DIV: begin
            if (x_done) begin
               state_in = grom_pkg::B_SQRT;
            end
         end
         grom_pkg::B_SQRT: begin
            if (root_done) begin
               state_in = grom_pkg::B_MUL;
            end
         end
         grom_pkg::B_MUL:   state_in = grom_pkg::B_SCORE;
         grom_pkg::B_SCORE: state_in = grom_pkg::B_CMP;
         grom_pkg::B_CMP:   state_in = grom_pkg::B_READ;
         grom_pkg::B_DONE:  state_in = grom_pkg::B_IDLE;
         default:           state_in = grom_pkg::B_IDLE;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      cmd_take   = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         grom_pkg::B_IDLE:  cmd_take   = cmd_chan.valid;
         grom_pkg::B_CHECK: div_start  = !(zero_case || coincident);
         grom_pkg::B_DIV:   sqrt_start = x_done;
         grom_pkg::B_DONE:  rsp_strobe = 1'b1;
         default: begin
            cmd_take = 1'b0;
         end
      endcase
   end

   assign cmd_pop = cmd_take;

   // Table state: count, used flags and the candidate memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= grom_pkg::B_IDLE;
         count_ff  <= '0;
         in_use_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (cmd_take && cmd_chan.cmd.op == grom_pkg::CMD_CLEAR) begin
            count_ff  <= '0;
            in_use_ff <= '0;
         end else if (cmd_take && cmd_chan.cmd.op == grom_pkg::CMD_APPEND && !table_full) begin
            count_ff <= count_ff + 1'b1;
            in_use_ff[count_ff[grom_pkg::IDX_BITS-1:0]] <= 1'b0;
         end
         if (state_ff == grom_pkg::B_DONE && best_ff != '0) begin
            in_use_ff[best_slot_ff] <= 1'b1;
         end
      end
      if (cmd_take && cmd_chan.cmd.op == grom_pkg::CMD_APPEND && !table_full) begin
         rect_mem_ff[count_ff[grom_pkg::IDX_BITS-1:0]] <= cmd_chan.cmd.rect;
      end
      if (state_ff == grom_pkg::B_READ) begin
         cand_ff <= rect_mem_ff[slot_idx];
      end
   end

   // Scan datapath, one stage of work per sequencer state.
   always_ff @(posedge clock) begin
      case (state_ff)
         grom_pkg::B_IDLE: begin
            query_ff     <= cmd_chan.cmd.rect;
            tag_ff       <= cmd_chan.cmd.tag;
            slot_ff      <= '0;
            best_ff      <= '0;
            best_slot_ff <= '0;
         end
         grom_pkg::B_READ: begin
            if (!scan_end && slot_used) begin
               slot_ff <= slot_ff + 1'b1;
            end
         end
         grom_pkg::B_SPAN: begin
            ow_ff  <= (hi_x > lo_x) ? hi_x - lo_x : '0;
            oh_ff  <= (hi_y > lo_y) ? hi_y - lo_y : '0;
            adx_ff <= (qc_x > cc_x) ? qc_x - cc_x : cc_x - qc_x;
            ady_ff <= (qc_y > cc_y) ? qc_y - cc_y : cc_y - qc_y;
            lw_ff  <= lw_sum[EB-1:1];
            lh_ff  <= lh_sum[EB-1:1];
         end
         grom_pkg::B_PROD: begin
            a1_ff  <= query_ff.w * query_ff.h;
            a2_ff  <= cand_ff.w * cand_ff.h;
            a0_ff  <= ow_ff * oh_ff;
            dx2_ff <= adx_ff * adx_ff;
            dy2_ff <= ady_ff * ady_ff;
            lw2_ff <= lw_ff * lw_ff;
            lh2_ff <= lh_ff * lh_ff;
         end
         grom_pkg::B_SUMS: begin
            a0s_ff <= a0_ff;
            uni_ff <= grom_pkg::UNION_BITS'({1'b0, a1_ff} + {1'b0, a2_ff} - a0_ff);
            dsq_ff <= {1'b0, dx2_ff} + {1'b0, dy2_ff};
            lsq_ff <= {1'b0, lw2_ff} + {1'b0, lh2_ff};
         end
         grom_pkg::B_CHECK: begin
            score_ff <= zero_case ? '0 : grom_pkg::SCORE_SAT;
         end
         grom_pkg::B_MUL: begin
            prod_ff <= ov_quo[grom_pkg::OV_BITS-1:0] * root;
         end
         grom_pkg::B_SCORE: begin
            score_ff <= grom_pkg::SCORE_BITS'(prod_ff[grom_pkg::PROD_BITS-1:grom_pkg::FRAC_BITS]);
         end
         grom_pkg::B_CMP: begin
            if (score_ff >= best_ff) begin
               best_ff      <= score_ff;
               best_slot_ff <= slot_idx;
            end
            slot_ff <= slot_ff + 1'b1;
         end
         default: begin
            tag_ff <= tag_ff;
         end
      endcase
   end

   // Overlap ratio and squared length-over-distance dividers.
   grom_div u_ov_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (grom_pkg::NUM_BITS'({a0s_ff, {grom_pkg::FRAC_BITS{1'b0}}})),
      .den   (grom_pkg::DEN_BITS'(uni_ff)),
      .done  (ov_done),
      .quo   (ov_quo)
   );

   grom_div u_x_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({lsq_ff, {(2 * grom_pkg::FRAC_BITS){1'b0}}}),
      .den   (dsq_ff),
      .done  (x_done),
      .quo   (x_quo)
   );

   grom_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (grom_pkg::RAD_BITS'(x_quo)),
      .done     (root_done),
      .root     (root)
   );

   // Match result.
   always_comb begin
      rsp_item.matched     = (best_ff != '0);
      rsp_item.match_slot  = (best_ff != '0) ? grom_pkg::SLOT_BITS'(best_slot_ff) : '0;
      rsp_item.match_score = best_ff;
      rsp_item.echo_tag    = tag_ff;
   end

   // Both dividers run in lockstep.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      ov_done == x_done)
      else $error("overlap and distance dividers out of step");

   // A reported match consumes its slot.
   a_match_consumes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.matched |=> in_use_ff[$past(best_slot_ff)])
      else $error("matched slot not marked used");

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= grom_pkg::CNT_BITS'(grom_pkg::TABLE_DEPTH))
      else $error("slot count beyond table depth");

   // A match result appears only after the scan reached the end of the table.
   a_scan_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == grom_pkg::B_READ && $past(scan_end))
      else $error("result before scan finished");

endmodule

FILE: src/greedy_rect_overlap_matcher.sv
// Top level of the greedy rectangle overlap matcher.
// Depends on grom_pkg, grom_front and grom_back.
//
// Channel   Ports                    Handshake
// request   start, busy, req_item    beat taken when start and not busy
// result    rsp_strobe, rsp_item     one-cycle strobe, never stalled
//
// A taken beat is registered in the command queue before the back end sees it.
// Clear and append complete as the back end takes them from the queue. A match
// scans the table one slot at a time: it skips consumed slots, sends an unused
// slot that scores zero or saturates straight to the compare, and runs every
// other unused slot through the 57-step divider and 29-step square-root unit.
// Reset is synchronous and active high; it empties the queue and the table.
// busy rises when the two-entry command queue is full; results cannot stall.
module greedy_rect_overlap_matcher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  grom_pkg::req_payload_type req_item,
   output logic                      rsp_strobe,
   output grom_pkg::rsp_payload_type rsp_item
);

   grom_pkg::cmd_chan_type cmd_chan;
   logic                   cmd_pop;

   grom_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .cmd_chan (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   grom_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_chan   (cmd_chan),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
